[rtl/core/rms_pkg.sv]
// Shared types and constants for the resistance matrix scanner.
// Used by the scanner top level, its serial divider and its port checker.
// No dependencies.
package rms_pkg;

	localparam int ADC_W          = 12;
	localparam int SUM_W          = 16;
	localparam int RES_W          = 26;
	localparam int NODE_W         = 3;
	localparam int ATT_W          = 10;
	localparam int THR_W          = 20;
	localparam int PROD_W         = 30;
	localparam int SCALE_W        = 18;
	localparam int IN_DATA_W      = 16;
	localparam int OUT_DATA_W     = 48;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 20;

	// Divider operand widths: the dividend covers both the sample sum and the
	// scaled mean, the divisor covers both the sample count and 4095 - mean.
	localparam int DIV_DIVIDEND_W = PROD_W;
	localparam int DIV_DIVISOR_W  = ADC_W;

	localparam logic [RES_W-1:0]   OPEN_Q4       = 26'd16000000;
	localparam logic [ADC_W-1:0]   OPEN_MIN_ADC  = 12'd4083;
	localparam logic [ADC_W-1:0]   SHORT_MAX_ADC = 12'd12;
	localparam logic [ADC_W-1:0]   ADC_FULL      = 12'd4095;
	localparam logic [SCALE_W-1:0] SCALE_Q4      = 18'd160000;

	// Result status codes.
	localparam logic [1:0] ST_RUNNING     = 2'd0;
	localparam logic [1:0] ST_MATRIX_DONE = 2'd1;
	localparam logic [1:0] ST_STABLE      = 2'd2;
	localparam logic [1:0] ST_GAVE_UP     = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd2;

	// Result item as packed into the output tdata, last field lowest.
	typedef struct packed {
		logic [4:0]        pad;
		logic [ATT_W-1:0]  attempt_number;
		logic              over_threshold;
		logic [RES_W-1:0]  resistance_q4;
		logic [NODE_W-1:0] col_node;
		logic [NODE_W-1:0] row_node;
	} rms_out_t;

	typedef struct packed {
		logic                      start;
		logic [DIV_DIVIDEND_W-1:0] dividend;
		logic [DIV_DIVISOR_W-1:0]  divisor;
	} rms_div_req_t;

	typedef struct packed {
		logic                      done;
		logic [DIV_DIVIDEND_W-1:0] quotient;
	} rms_div_rsp_t;

endpackage

[rtl/core/rms_div.sv]
// Restoring bit-serial divider, one quotient bit per clock.
// Depends on rms_pkg for operand widths and the request/response structs.
module rms_div import rms_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rms_div_req_t req,
	output rms_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_DIVIDEND_W + 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DIV_DIVIDEND_W-1:0] shreg_q;
	logic [DIV_DIVISOR_W-1:0]  rem_q;
	logic [DIV_DIVISOR_W-1:0]  dvs_q;
	logic [DIV_DIVISOR_W:0]    rem_shift;
	logic [DIV_DIVISOR_W:0]    trial;
	logic                      fits;

	assign rem_shift = {rem_q, shreg_q[DIV_DIVIDEND_W-1]};
	assign trial     = rem_shift - {1'b0, dvs_q};
	assign fits      = (rem_shift >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers carry no reset.
	always_ff @(posedge clk) begin
		if (req.start) begin
			shreg_q <= req.dividend;
			rem_q   <= '0;
			dvs_q   <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial[DIV_DIVISOR_W-1:0];
			end else begin
				rem_q <= rem_shift[DIV_DIVISOR_W-1:0];
			end
			shreg_q <= {shreg_q[DIV_DIVIDEND_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = shreg_q;

endmodule

[rtl/core/resistance_matrix_scanner.sv]
// Top level of the resistance matrix scanner: sample accumulation, scan sequencing
// and the result register. Depends on rms_pkg and instantiates rms_div.
//
// Usage: each input item on the s_axis channel is one 12-bit converter sample
// for the node pair currently selected; tuser carries the start request, which
// restarts the scan at the first pair before that sample is counted. After
// SAMPLES samples the block averages them, converts the mean to a resistance
// in 1/16 ohm and emits one result item on the m_axis channel, with tlast on
// the final pair of a matrix scan or diagonal pass and the scan status in tuser.
// Configuration writes (mode, threshold, attempt limit) go through the cfg
// channel, which is always ready, and are meant to happen while the block idles.
//
// A sample that does not complete a pair is only added to the running sum and
// count, and the input stays ready. The sample that completes a pair holds off
// the input through the mean division, the multiply, the divider load, the
// resistance division and the result register load. Both divisions run through
// the single shared restoring divider, one quotient bit per cycle; open and
// short readings skip the second division. A finished result sits in the output
// register; the block goes on taking samples while it waits and only holds in
// its final step if a new result is ready before the previous one was taken.
// Reset clears the scan to the first pair, attempt one, and sets the register
// defaults (mode 0, threshold 1300 ohm, 150 attempts); the scan runs at once.
module resistance_matrix_scanner import rms_pkg::*; #(
	parameter int NODE_COUNT = 8,
	parameter int SAMPLES    = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] adc_sample, rest zero
	input  logic                  s_axis_tuser,   // [0] start_req
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // row_node, col_node, resistance_q4,
	                                              // over_threshold, attempt_number, zeros
	output logic                  m_axis_tlast,   // last pair of a scan or pass
	output logic [1:0]            m_axis_tuser,   // [1:0] status
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(SAMPLES + 1);

	typedef enum logic [2:0] {
		IDLE,
		MEAN,
		MULT,
		RES_LOAD,
		RES,
		FINISH
	} state_t;

	// Configuration registers.
	logic             scan_mode_q;
	logic [THR_W-1:0] threshold_q;
	logic [ATT_W-1:0] max_attempts_q;

	// Scan state.
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NODE_W-1:0] row_q;
	logic [NODE_W-1:0] col_q;
	logic [ATT_W-1:0]  attempt_q;
	logic              stable_q;
	logic              finished_q;

	// Per-pair working registers.
	logic [ADC_W-1:0]  mean_q;
	logic [PROD_W-1:0] prod_q;
	logic [RES_W-1:0]  res_q;

	// Output register.
	logic              out_valid_q;
	rms_out_t          out_data_q;
	logic              out_last_q;
	logic [1:0]        out_status_q;

	rms_div_req_t div_req;
	rms_div_rsp_t div_rsp;

	logic              in_accept;
	logic              start_req;
	logic [ADC_W-1:0]  adc_sample;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  count_new;
	logic              pair_done;
	logic              out_free;
	logic              over;
	logic [ATT_W-1:0]  limit;
	logic              row_end;
	logic              col_end;
	logic              stable_eff;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign adc_sample    = s_axis_tdata[ADC_W-1:0];
	assign start_req     = s_axis_tuser;

	// A start request wipes the partial sum before this sample is added.
	assign sum_new   = (start_req ? '0 : sum_q) + {{(SUM_W-ADC_W){1'b0}}, adc_sample};
	assign count_new = (start_req ? '0 : count_q) + 1'b1;
	assign pair_done = in_accept && (start_req || !finished_q)
	                   && (count_new >= CNT_W'(SAMPLES));

	assign out_free  = !out_valid_q || m_axis_tready;
	assign over      = (res_q > {2'b00, threshold_q, 4'b0000});
	assign limit     = (max_attempts_q == '0) ? ATT_W'(1) : max_attempts_q;
	assign row_end   = (row_q == NODE_W'(NODE_COUNT - 1));
	assign col_end   = (col_q == NODE_W'(NODE_COUNT - 1));
	assign stable_eff = stable_q && !over;

	// The shared divider first divides the sum by the sample count, then the
	// scaled mean by the distance of the mean from full scale.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {{(PROD_W-SUM_W){1'b0}}, sum_new};
		div_req.divisor  = DIV_DIVISOR_W'(SAMPLES);
		if (state_q == IDLE) begin
			div_req.start = pair_done;
		end else if (state_q == RES_LOAD) begin
			div_req.start    = 1'b1;
			div_req.dividend = prod_q;
			div_req.divisor  = ADC_FULL - mean_q;
		end
	end

	rms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q    <= 1'b0;
			threshold_q    <= THR_W'(1300);
			max_attempts_q <= ATT_W'(150);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCAN_MODE:    scan_mode_q    <= cfg_data[0];
				CFG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			count_q      <= '0;
			sum_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			attempt_q    <= ATT_W'(1);
			stable_q     <= 1'b1;
			finished_q   <= 1'b0;
			mean_q       <= '0;
			prod_q       <= '0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= ST_RUNNING;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_accept) begin
						if (start_req) begin
							row_q      <= '0;
							col_q      <= '0;
							attempt_q  <= ATT_W'(1);
							stable_q   <= 1'b1;
							finished_q <= 1'b0;
							count_q    <= '0;
							sum_q      <= '0;
						end
						if (start_req || !finished_q) begin
							if (pair_done) begin
								count_q <= '0;
								sum_q   <= '0;
								state_q <= MEAN;
							end else begin
								count_q <= count_new;
								sum_q   <= sum_new;
							end
						end
					end
				end
				MEAN: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quotient[ADC_W-1:0];
						state_q <= MULT;
					end
				end
				MULT: begin
					// Open and short readings are clamped without a division.
					if (mean_q >= OPEN_MIN_ADC) begin
						res_q   <= OPEN_Q4;
						state_q <= FINISH;
					end else if (mean_q <= SHORT_MAX_ADC) begin
						res_q   <= '0;
						state_q <= FINISH;
					end else begin
						prod_q  <= {{(PROD_W-SCALE_W){1'b0}}, SCALE_Q4}
						           * {{(PROD_W-ADC_W){1'b0}}, mean_q};
						state_q <= RES_LOAD;
					end
				end
				RES_LOAD: begin
					state_q <= RES;
				end
				RES: begin
					if (div_rsp.done) begin
						res_q   <= div_rsp.quotient[RES_W-1:0];
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						out_valid_q                   <= 1'b1;
						out_data_q.pad                <= '0;
						out_data_q.resistance_q4      <= res_q;
						out_data_q.over_threshold     <= over;
						out_data_q.row_node           <= row_q;
						out_last_q                    <= 1'b0;
						out_status_q                  <= ST_RUNNING;
						state_q                       <= IDLE;
						if (!scan_mode_q) begin
							// Full matrix, row-major order.
							out_data_q.col_node       <= col_q;
							out_data_q.attempt_number <= '0;
							if (!col_end) begin
								col_q <= col_q + 1'b1;
							end else begin
								col_q <= '0;
								if (!row_end) begin
									row_q <= row_q + 1'b1;
								end else begin
									row_q        <= '0;
									out_last_q   <= 1'b1;
									out_status_q <= ST_MATRIX_DONE;
									finished_q   <= 1'b1;
								end
							end
						end else begin
							// Diagonal pass; the column tracks the row.
							out_data_q.col_node       <= row_q;
							out_data_q.attempt_number <= attempt_q;
							stable_q                  <= stable_eff;
							if (!row_end) begin
								row_q <= row_q + 1'b1;
								col_q <= row_q + 1'b1;
							end else begin
								row_q      <= '0;
								col_q      <= '0;
								out_last_q <= 1'b1;
								if (stable_eff) begin
									out_status_q <= ST_STABLE;
									finished_q   <= 1'b1;
								end else if (attempt_q >= limit) begin
									out_status_q <= ST_GAVE_UP;
									finished_q   <= 1'b1;
								end else begin
									attempt_q <= attempt_q + 1'b1;
									stable_q  <= 1'b1;
								end
							end
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

endmodule

[rtl/core/rms_checker.sv]
// Port-level checks for the resistance matrix scanner, bound to the top level.
// Depends on rms_pkg for the result layout and status codes.
module rms_checker import rms_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic [1:0]            m_axis_tuser
);

	rms_out_t res;
	assign res = rms_out_t'(m_axis_tdata);

	// A stalled result must hold until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Only the last pair of a scan or pass can end the scan.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_RUNNING |-> m_axis_tlast)
		else $error("final status without last");

	// Off-diagonal pairs come only from the full matrix scan.
	a_offdiag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.row_node != res.col_node |-> res.attempt_number == '0)
		else $error("attempt number on an off-diagonal pair");

	// A reading over the threshold cannot be zero.
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.over_threshold |-> res.resistance_q4 != '0)
		else $error("over threshold with zero resistance");

endmodule

bind resistance_matrix_scanner rms_checker u_rms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
